// ===== design/nca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest centroid assignment block.
// No dependencies; imported by the distance unit, the top level and the checker.
package nca_pkg;

    localparam int VAL_W  = 16;
    localparam int IDX_W  = 4;
    localparam int NC_W   = 5;
    localparam int DIFF_W = 17;
    localparam int SQ_W   = 32;
    localparam int ACC_W  = 37;
    localparam int OUT_W  = 36;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;

    localparam int TU_REQ   = 0;
    localparam int TU_DONLY = 1;

    localparam logic REQ_CENTER = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic last;
        logic donly;
        logic dvalid;
    } t_smp_ctl;

endpackage

// ===== design/nca_center_mem.sv =====
`timescale 1ns / 1ps
// Centre coordinate store: one write port, one registered read port.
// Depends on nothing but the clock.
module nca_center_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/nca_dist_unit.sv =====
`timescale 1ns / 1ps
// Shared distance unit: difference, square, saturating accumulate and nearest search.
// Depends on nca_pkg; fed one centre per cycle by the top-level sequencer.
module nca_dist_unit #(
    parameter int MAX_CENTERS = 16,
    parameter int KW          = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [KW-1:0]            i_k,
    input  logic [nca_pkg::VAL_W-1:0] i_center,
    input  logic [nca_pkg::VAL_W-1:0] i_value,
    input  nca_pkg::t_smp_ctl        i_ctl,
    input  logic [nca_pkg::IDX_W-1:0] i_glabel,
    input  logic [KW-1:0]            i_kn_last,
    output logic                     o_done,
    output logic [nca_pkg::IDX_W-1:0] o_label,
    output logic [nca_pkg::OUT_W-1:0] o_dist
);
    import nca_pkg::*;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    logic [SQ_W-1:0]            r_sq;
    logic [KW-1:0]              r_k2;
    logic                       r_v2;
    logic [ACC_W-1:0]           r_acc [MAX_CENTERS];
    logic [ACC_W:0]             sum;
    logic [ACC_W-1:0]           s;
    logic [KW-1:0]              r_best;
    logic [ACC_W-1:0]           r_bestd;
    logic                       in_range;
    logic                       is_glabel;

    assign diff = DIFF_W'($signed(i_value)) - DIFF_W'($signed(i_center));
    assign prod = diff * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
        end
        r_k2 <= i_k;
        r_sq <= i_ctl.dvalid ? prod[SQ_W-1:0] : '0;
    end

    assign sum       = {1'b0, r_acc[r_k2]} + (ACC_W+1)'(r_sq);
    assign s         = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    assign in_range  = 32'(r_k2) <= 32'(i_kn_last);
    assign is_glabel = 32'(r_k2) == 32'(i_glabel);
    assign o_done    = r_v2 && (32'(r_k2) == MAX_CENTERS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CENTERS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_v2) begin
            r_acc[r_k2] <= i_ctl.last ? '0 : s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            if (r_k2 == '0) begin
                r_best  <= '0;
                r_bestd <= (!i_ctl.donly || is_glabel) ? s : '0;
            end else if (i_ctl.donly) begin
                if (is_glabel) begin
                    r_bestd <= s;
                end
            end else if (in_range && (s < r_bestd)) begin
                r_best  <= r_k2;
                r_bestd <= s;
            end
        end
    end

    assign o_label = i_ctl.donly ? i_glabel : IDX_W'(r_best);
    assign o_dist  = (r_bestd > ACC_W'(OUT_MAX)) ? OUT_MAX : r_bestd[OUT_W-1:0];

endmodule

// ===== design/nearest_centroid_assign.sv =====
`timescale 1ns / 1ps
// Nearest centroid assignment: centre store, sequencer and shared distance unit.
// Depends on nca_pkg, nca_center_mem and nca_dist_unit.
//
// Usage: the slave stream carries centre writes (tuser req bit low) and sample
// coordinates (req bit high). A centre write is stored and the stream stays
// ready. While a sample coordinate is in progress the stream is not ready: the
// sequencer walks every centre through one shared subtract, square and
// accumulate unit, one centre a cycle, behind the registered store read.
// tlast marks the sample's last coordinate; once the walk for that transfer is
// through, m_axis_tvalid rises with the nearest centre (or the given label in
// distance-only mode) and its squared distance, and all running distances clear.
// A new coordinate is taken only once the last one is through. A waiting result
// sits in the output register and further items are taken; a new result waits,
// with the stream not ready, until the receiver takes the old one. Reset clears
// the running distances, sets num_centers to 1 and empties the output; centre
// coordinates stay undefined until written. i_cfg_we writes num_centers from
// i_cfg_wdata; the user must write only while the block is idle (not enforced).
module nearest_centroid_assign #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // center_index[3:0], coord_index[7:4], coord_value[23:8], given_label[27:24]
    input  logic [nca_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    // req_type[0], distance_only[1]
    input  logic [nca_pkg::S_USER_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // best_label[3:0], min_distance[39:4]
    output logic [nca_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [nca_pkg::NC_W-1:0]      i_cfg_wdata
);
    import nca_pkg::*;

    localparam int KW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DEPTH = MAX_CENTERS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_k1;
    logic                r_v1;
    logic [IDX_W-1:0]    r_didx;
    logic [VAL_W-1:0]    r_value;
    t_smp_ctl            r_ctl;
    logic [IDX_W-1:0]    r_glabel;
    logic [NC_W-1:0]     r_num_centers;
    logic                r_mvalid;
    logic [M_DATA_W-1:0] r_mdata;

    logic                s_acc;
    logic                req;
    logic [IDX_W-1:0]    f_cidx;
    logic [IDX_W-1:0]    f_didx;
    logic [VAL_W-1:0]    f_value;
    logic [IDX_W-1:0]    f_glabel;
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [VAL_W-1:0]    rdata;
    logic [KW-1:0]       kn_last;
    logic                done;
    logic [IDX_W-1:0]    res_label;
    logic [OUT_W-1:0]    res_dist;
    logic                out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign req           = s_axis_tuser[TU_REQ];
    assign f_cidx        = s_axis_tdata[3:0];
    assign f_didx        = s_axis_tdata[7:4];
    assign f_value       = s_axis_tdata[23:8];
    assign f_glabel      = s_axis_tdata[27:24];

    assign mem_we = s_acc && (req == REQ_CENTER)
                    && (32'(f_cidx) < MAX_CENTERS) && (32'(f_didx) < MAX_DIMS);
    assign waddr  = AW'(32'(f_cidx) * MAX_DIMS + 32'(f_didx));
    assign raddr  = AW'(32'(r_k) * MAX_DIMS + 32'(r_didx));

    always_comb begin
        if (r_num_centers == '0) begin
            kn_last = '0;
        end else if (32'(r_num_centers) > MAX_CENTERS) begin
            kn_last = KW'(MAX_CENTERS - 1);
        end else begin
            kn_last = KW'(r_num_centers - 1'b1);
        end
    end

    nca_center_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VAL_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (f_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nca_dist_unit #(
        .MAX_CENTERS (MAX_CENTERS),
        .KW          (KW)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v1),
        .i_k       (r_k1),
        .i_center  (rdata),
        .i_value   (r_value),
        .i_ctl     (r_ctl),
        .i_glabel  (r_glabel),
        .i_kn_last (kn_last),
        .o_done    (done),
        .o_label   (res_label),
        .o_dist    (res_dist)
    );

    assign out_free = !r_mvalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && (req == REQ_SAMPLE)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (32'(r_k) == MAX_CENTERS - 1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    n_state = r_ctl.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_v1          <= 1'b0;
            r_num_centers <= NC_W'(1);
            r_mvalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_RUN);
            if (i_cfg_we) begin
                r_num_centers <= i_cfg_wdata;
            end
            if ((r_state == ST_EMIT) && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1 <= r_k;
        if (s_acc && (req == REQ_SAMPLE)) begin
            r_k          <= '0;
            r_didx       <= f_didx;
            r_value      <= f_value;
            r_glabel     <= f_glabel;
            r_ctl.last   <= s_axis_tlast;
            r_ctl.donly  <= s_axis_tuser[TU_DONLY];
            r_ctl.dvalid <= 32'(f_didx) < MAX_DIMS;
        end else if (r_state == ST_RUN) begin
            r_k <= r_k + 1'b1;
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_mdata <= {res_dist, res_label};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

// ===== design/nca_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the nearest centroid assignment block, bound to the top.
// Depends on nca_pkg and the top-level port names.
module nca_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [nca_pkg::S_USER_W-1:0] s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [nca_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import nca_pkg::*;

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && (s_axis_tuser[TU_REQ] == REQ_SAMPLE)) |=> !s_axis_tready)
        else $error("ready while a sample coordinate is in progress");

    a_center_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && (s_axis_tuser[TU_REQ] == REQ_CENTER)) |=> s_axis_tready)
        else $error("centre write stalled the input");

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (.*);

// ===== sim/tb_nearest_centroid_assign.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nearest_centroid_assign: a directed table, then random centre
// writes, samples and noise, checked against an in-bench distance and search predictor.
// Depends on nca_pkg and nearest_centroid_assign.
module tb_nearest_centroid_assign;
    import nca_pkg::*;

    localparam int N_CENTRES = 16;
    localparam int N_DIMS    = 16;
    localparam int SETTLE    = 40;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic             req;
        logic [3:0]       cidx;
        logic [3:0]       didx;
        logic [15:0]      val;
        logic             last;
        logic             donly;
        logic [3:0]       glabel;
        logic [7:0]       reps;
        logic             chk;
        logic [3:0]       xlabel;
        logic [OUT_W-1:0] xdist;
    } t_row;

    typedef struct packed {
        logic [3:0]       label;
        logic [OUT_W-1:0] sqd;
    } t_assign;

    typedef struct packed {
        logic             chk;
        logic [3:0]       label;
        logic [OUT_W-1:0] sqd;
    } t_listed;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic [NC_W-1:0]     i_cfg_wdata   = '0;

    logic signed [15:0]  centre_coords [N_CENTRES][N_DIMS];
    logic [ACC_W-1:0]    running_dist [N_CENTRES];
    logic [NC_W-1:0]     nc_setting;
    t_assign             pending_assign [$];
    t_listed             listed_assign [$];
    t_row                plan [$];

    int errors    = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_sat     = 0;
    int n_donly   = 0;
    int quiet_left = 0;
    int rx_hold    = 0;
    bit rx_rdy     = 1'b0;

    nearest_centroid_assign #(
        .MAX_CENTERS (N_CENTRES),
        .MAX_DIMS    (N_DIMS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (errors < 20) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        errors++;
    endtask

    // Predictor: centre store, running distances and nearest-centre search.
    task automatic take_transfer(input logic [S_DATA_W-1:0] d, input logic [S_USER_W-1:0] u,
                                 input logic l);
        logic [3:0]         di;
        logic [3:0]         gl;
        logic signed [15:0] v;
        longint             dv;
        longint             sum;
        logic [ACC_W-1:0]   bd;
        int                 span;
        int                 best;
        t_assign            a;
        di = d[7:4];
        v  = d[23:8];
        gl = d[27:24];
        if (u[TU_REQ] == REQ_CENTER) begin
            centre_coords[d[3:0]][di] = v;
        end else begin
            for (int k = 0; k < N_CENTRES; k++) begin
                dv  = longint'(v) - longint'(centre_coords[k][di]);
                sum = longint'(running_dist[k]) + dv * dv;
                running_dist[k] = (sum > longint'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
            end
            if (l) begin
                if (u[TU_DONLY]) begin
                    best = gl;
                    bd   = running_dist[gl];
                    n_donly++;
                end else begin
                    span = (nc_setting == 0) ? 1 : (nc_setting > N_CENTRES) ? N_CENTRES : nc_setting;
                    best = 0;
                    bd   = running_dist[0];
                    for (int k = 1; k < span; k++) begin
                        if (running_dist[k] < bd) begin
                            bd   = running_dist[k];
                            best = k;
                        end
                    end
                end
                a.label = best[3:0];
                a.sqd   = bd[ACC_W-1] ? OUT_MAX : bd[OUT_W-1:0];
                if (a.sqd == OUT_MAX) begin
                    n_sat++;
                end
                pending_assign.push_back(a);
                for (int k = 0; k < N_CENTRES; k++) begin
                    running_dist[k] = '0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_assign e;
        t_listed x;
        if (!i_rst_n) begin
            nc_setting = NC_W'(1);
            for (int c = 0; c < N_CENTRES; c++) begin
                running_dist[c] = '0;
                for (int d = 0; d < N_DIMS; d++) begin
                    centre_coords[c][d] = '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                nc_setting = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_transfer(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            end
            if ($isunknown(m_axis_tvalid)) begin
                report_mismatch("output valid unknown");
            end else if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_assign.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    e = pending_assign.pop_front();
                    if (listed_assign.size() != 0) begin
                        x = listed_assign.pop_front();
                        if (x.chk) begin
                            e.label = x.label;
                            e.sqd   = x.sqd;
                        end
                    end
                    if (m_axis_tdata[3:0] !== e.label) begin
                        report_mismatch($sformatf("best_label %0d, expected %0d",
                                                  m_axis_tdata[3:0], e.label));
                    end
                    if (m_axis_tdata[39:4] !== e.sqd) begin
                        report_mismatch($sformatf("min_distance %0d, expected %0d",
                                                  m_axis_tdata[39:4], e.sqd));
                    end
                end
            end
        end
    end

    // Receiver: mostly short stalls, the odd long one, and stall-free stretches.
    always @(posedge i_clk) begin : sink
        int r;
        if (rx_hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                rx_rdy  = 1'b1;
                rx_hold = $urandom_range(1, 8);
            end else if (r < 90) begin
                rx_rdy  = 1'b0;
                rx_hold = $urandom_range(1, 3);
            end else if (r < 97) begin
                rx_rdy  = 1'b1;
                rx_hold = $urandom_range(30, 80);
            end else begin
                rx_rdy  = 1'b0;
                rx_hold = $urandom_range(20, 60);
            end
        end
        rx_hold--;
        m_axis_tready <= rx_rdy;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 10) begin
            quiet_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 500) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 980) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_item(input t_row r);
        int      gap;
        t_listed x;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, r.glabel, r.val, r.didx, r.cidx};
        s_axis_tlast  <= r.last;
        s_axis_tuser  <= {r.donly, r.req};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (r.req == REQ_SAMPLE && r.last) begin
            x.chk   = r.chk;
            x.label = r.xlabel;
            x.sqd   = r.xdist;
            listed_assign.push_back(x);
        end
        n_items++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_assign.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_centre_count(input logic [NC_W-1:0] n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_row cfg_row(input logic [NC_W-1:0] n);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.val  = 16'(n);
        return r;
    endfunction

    function automatic t_row centre_row(input int c, input int d, input logic [15:0] v,
                                        input logic stray);
        t_row r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.req    = REQ_CENTER;
        r.cidx   = c[3:0];
        r.didx   = d[3:0];
        r.val    = v;
        r.last   = stray;
        r.donly  = stray;
        r.glabel = {4{stray}};
        r.reps   = 8'd1;
        return r;
    endfunction

    function automatic t_row sample_row(input int d, input logic [15:0] v, input logic l,
                                        input logic donly, input int gl, input int reps,
                                        input logic chk, input int xl,
                                        input logic [OUT_W-1:0] xd);
        t_row r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.req    = REQ_SAMPLE;
        r.didx   = d[3:0];
        r.val    = v;
        r.last   = l;
        r.donly  = donly;
        r.glabel = gl[3:0];
        r.reps   = reps[7:0];
        r.chk    = chk;
        r.xlabel = xl[3:0];
        r.xdist  = xd;
        return r;
    endfunction

    task automatic send_sample();
        int   len;
        int   start;
        int   tgt;
        int   r;
        bit   scatter;
        t_row it;
        len     = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 40);
        start   = $urandom_range(0, N_DIMS - 1);
        tgt     = $urandom_range(0, N_CENTRES - 1);
        scatter = ($urandom_range(0, 99) < 25);
        for (int i = 0; i < len; i++) begin
            it      = '0;
            it.kind = ROW_ITEM;
            it.req  = REQ_SAMPLE;
            it.reps = 8'd1;
            it.didx = scatter ? 4'($urandom_range(0, N_DIMS - 1)) : 4'((start + i) % N_DIMS);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                it.val = centre_coords[tgt][it.didx] + 16'($urandom_range(0, 6) - 3);
            end else if (r < 80) begin
                it.val = 16'($urandom);
            end else begin
                it.val = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            end
            it.last   = (i == len - 1);
            it.donly  = ($urandom_range(0, 99) < 30);
            it.glabel = 4'($urandom_range(0, 15));
            put_item(it);
        end
    endtask

    task automatic send_centres();
        int   n;
        int   r;
        t_row it;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            it        = '0;
            it.kind   = ROW_ITEM;
            it.req    = REQ_CENTER;
            it.reps   = 8'd1;
            it.cidx   = 4'($urandom_range(0, 15));
            it.didx   = 4'($urandom_range(0, 15));
            it.last   = $urandom_range(0, 1);
            it.donly  = $urandom_range(0, 1);
            it.glabel = 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (r < 30) begin
                it.val = centre_coords[$urandom_range(0, N_CENTRES - 1)][it.didx];
            end else if (r < 45) begin
                it.val = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            end else begin
                it.val = 16'($urandom);
            end
            put_item(it);
        end
    endtask

    task automatic send_noise();
        t_row it;
        it        = '0;
        it.kind   = ROW_ITEM;
        it.reps   = 8'd1;
        it.req    = $urandom_range(0, 1);
        it.cidx   = 4'($urandom_range(0, 15));
        it.didx   = 4'($urandom_range(0, 15));
        it.val    = 16'($urandom);
        it.last   = $urandom_range(0, 1);
        it.donly  = $urandom_range(0, 1);
        it.glabel = 4'($urandom_range(0, 15));
        put_item(it);
    endtask

    initial begin : stimulus
        t_row        it;
        int          r;
        int          target;
        logic [4:0]  counts [6];
        counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd0};
        counts[5] = 5'($urandom_range(2, 15));

        plan.push_back(cfg_row(5'd1));
        plan.push_back(centre_row(0, 0, 16'h8000, 1'b0));
        plan.push_back(centre_row(1, 0, 16'h7fff, 1'b0));
        plan.push_back(sample_row(0, 16'h7fff, 1, 1, 0, 1, 1, 0, 36'd4294836225));
        plan.push_back(sample_row(0, 16'h8000, 1, 1, 1, 1, 1, 1, 36'd4294836225));
        plan.push_back(sample_row(0, 16'h7fff, 1, 1, 0, 40, 1, 0, OUT_MAX));
        plan.push_back(sample_row(0, 16'h8000, 1, 0, 9, 1, 1, 0, 36'd0));
        plan.push_back(cfg_row(5'd2));
        plan.push_back(centre_row(0, 1, 16'h0064, 1'b0));
        plan.push_back(centre_row(1, 1, 16'h0064, 1'b0));
        plan.push_back(sample_row(1, 16'h0064, 1, 0, 5, 1, 1, 0, 36'd0));
        plan.push_back(centre_row(0, 2, 16'h012c, 1'b0));
        plan.push_back(centre_row(1, 2, 16'h0005, 1'b0));
        plan.push_back(sample_row(2, 16'h0005, 1, 0, 0, 1, 1, 1, 36'd0));
        plan.push_back(sample_row(3, 16'h4321, 0, 1, 7, 1, 0, 0, 36'd0));
        plan.push_back(centre_row(2, 3, 16'h1234, 1'b1));
        plan.push_back(sample_row(4, 16'hffff, 1, 0, 3, 1, 0, 0, 36'd0));
        plan.push_back(cfg_row(5'd0));
        plan.push_back(sample_row(5, 16'h0000, 1, 0, 2, 1, 0, 0, 36'd0));
        plan.push_back(cfg_row(5'd31));
        plan.push_back(sample_row(6, 16'h7fff, 1, 0, 4, 1, 0, 0, 36'd0));
        plan.push_back(cfg_row(5'd16));
        plan.push_back(sample_row(15, 16'h8000, 0, 0, 0, 1, 0, 0, 36'd0));
        plan.push_back(sample_row(15, 16'h7fff, 1, 1, 15, 1, 0, 0, 36'd0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every centre coordinate so that no sample reads an unwritten entry
        for (int c = 0; c < N_CENTRES; c++) begin
            for (int d = 0; d < N_DIMS; d++) begin
                put_item(centre_row(c, d, 16'($urandom), 1'b0));
            end
        end

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                load_centre_count(plan[i].val[NC_W-1:0]);
            end else begin
                for (int k = 0; k < plan[i].reps; k++) begin
                    it      = plan[i];
                    it.last = plan[i].last && (k == plan[i].reps - 1);
                    put_item(it);
                end
            end
        end

        for (int p = 0; p < 6; p++) begin
            load_centre_count(counts[p]);
            target = n_items + 250;
            while (n_items < target) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_sample();
                end else if (r < 85) begin
                    send_centres();
                end else begin
                    send_noise();
                end
            end
        end

        drain();
        $display("run: %0d input transfers, %0d results checked (%0d distance-only, %0d saturated)",
                 n_items, n_results, n_donly, n_sat);
        $display("run: centre counts 1, 2, 0, 31, 16 directed; 16, 1, 0, 31, 7, %0d random",
                 counts[5]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
